### design/simc_pkg.sv
package simc_pkg;

  localparam int NUM_MODES   = 4;
  localparam int TABLE_MODES = 4;
  localparam int MIDX_W      = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUS_MAX = 3'd0,
    CFG_MASK0   = 3'd1,
    CFG_MASK1   = 3'd2,
    CFG_MASK2   = 3'd3,
    CFG_MASK3   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  mode_index;
    logic [11:0] reg_offset;
    logic [31:0] write_data;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        response_code;
    logic [18:0] packet_bytes_now;
  } out_t;

  typedef struct packed {
    logic [15:0]      bus_max;
    logic [3:0][31:0] mask;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_RD_MAXSZ,
    OP_RD_UNITSZ,
    OP_RD_POS,
    OP_RD_SIZE,
    OP_RD_CODING,
    OP_RD_INQ,
    OP_RD_PIX,
    OP_RD_FRAME,
    OP_RD_ENV,
    OP_RD_PKT,
    OP_RD_PPF,
    OP_WR_POS,
    OP_WR_SIZE,
    OP_WR_CODING,
    OP_WR_PKT
  } op_e;

  typedef struct packed {
    op_e         op;
    logic        mode_ok;
    logic [1:0]  mode;
    logic [31:0] data;
  } job_t;

  function automatic logic [MIDX_W-1:0] midx(input logic [1:0] m);
    return MIDX_W'(m);
  endfunction

  function automatic logic [15:0] def_w(input int m);
    case (m)
      0: return 16'd1388;
      1: return 16'd1280;
      2: return 16'd640;
      3: return 16'd320;
      default: return 16'd0;
    endcase
  endfunction

  function automatic logic [15:0] def_h(input int m);
    case (m)
      0: return 16'd1032;
      1: return 16'd960;
      2: return 16'd480;
      3: return 16'd240;
      default: return 16'd0;
    endcase
  endfunction

  function automatic logic [31:0] max_word(input logic [1:0] m);
    case (m)
      2'd0: return {16'd1575, 16'd1053};
      2'd1: return {16'd1280, 16'd960};
      2'd2: return {16'd640, 16'd480};
      default: return {16'd320, 16'd240};
    endcase
  endfunction

  function automatic logic [31:0] unit_word(input logic [1:0] m);
    case (m)
      2'd1, 2'd2: return {16'd8, 16'd8};
      default: return {16'd4, 16'd4};
    endcase
  endfunction

  function automatic logic [5:0] bits_of(input logic [7:0] c);
    case (c)
      8'd0, 8'd7, 8'd8: return 6'd8;
      8'd1: return 6'd12;
      8'd2, 8'd5: return 6'd16;
      8'd3, 8'd4: return 6'd24;
      8'd6: return 6'd48;
      default: return 6'd0;
    endcase
  endfunction

  // line is width times bits per pixel; round to bytes, then to a quadlet
  function automatic logic [18:0] unit_from_line(input logic [21:0] line);
    logic [22:0] lp;
    logic [19:0] us;
    lp = {1'b0, line} + 23'd7;
    us = (lp[22:3] + 20'd3) & ~20'd3;
    return (us == 20'd0) ? 19'd4 : us[18:0];
  endfunction

endpackage

### design/simc_front.sv
module simc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  simc_pkg::in_t    in_data_i,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output simc_pkg::job_t   job_o
);

  simc_pkg::job_t q_d, q_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           do_push, do_pop;

  assign full        = (cnt_q == 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = job_valid_o && job_ready_i;

  // classify the access
  always_comb begin
    q_d.mode    = in_data_i.mode_index;
    q_d.data    = in_data_i.write_data;
    q_d.mode_ok = (32'(in_data_i.mode_index) < simc_pkg::NUM_MODES) &&
                  (32'(in_data_i.mode_index) < simc_pkg::TABLE_MODES);
    q_d.op      = simc_pkg::OP_NOP;
    if (!in_data_i.cmd) begin
      case (in_data_i.reg_offset)
        12'h000: q_d.op = simc_pkg::OP_RD_MAXSZ;
        12'h004: q_d.op = simc_pkg::OP_RD_UNITSZ;
        12'h008: q_d.op = simc_pkg::OP_RD_POS;
        12'h00C: q_d.op = simc_pkg::OP_RD_SIZE;
        12'h010: q_d.op = simc_pkg::OP_RD_CODING;
        12'h014: q_d.op = simc_pkg::OP_RD_INQ;
        12'h034: q_d.op = simc_pkg::OP_RD_PIX;
        12'h03C: q_d.op = simc_pkg::OP_RD_FRAME;
        12'h040: q_d.op = simc_pkg::OP_RD_ENV;
        12'h044: q_d.op = simc_pkg::OP_RD_PKT;
        12'h048: q_d.op = simc_pkg::OP_RD_PPF;
        default: q_d.op = simc_pkg::OP_NOP;
      endcase
    end else begin
      case (in_data_i.reg_offset)
        12'h008: q_d.op = simc_pkg::OP_WR_POS;
        12'h00C: q_d.op = simc_pkg::OP_WR_SIZE;
        12'h010: q_d.op = simc_pkg::OP_WR_CODING;
        12'h044: q_d.op = simc_pkg::OP_WR_PKT;
        default: q_d.op = simc_pkg::OP_NOP;
      endcase
    end
    if (!q_d.mode_ok) q_d.op = simc_pkg::OP_NOP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        q_q[wr_ptr_q] <= q_d;
        wr_ptr_q      <= !wr_ptr_q;
      end
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |=> (cnt_q == 2'd2) || (cnt_q == 2'd1))
    else $error("front queue count out of range");
`endif

endmodule

### design/simc_div.sv
module simc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [18:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [18:0] rem_o
);

  logic [31:0] quot_q;
  logic [19:0] rem_q;
  logic [18:0] dvs_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [19:0] trial;

  assign trial  = {rem_q[18:0], quot_q[31]};
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[18:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
        quot_q <= dividend_i;
        rem_q  <= 20'd0;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        // one quotient bit per cycle, restoring
        if (trial >= {1'b0, dvs_q}) begin
          rem_q  <= trial - {1'b0, dvs_q};
          quot_q <= {quot_q[30:0], 1'b1};
        end else begin
          rem_q  <= trial;
          quot_q <= {quot_q[30:0], 1'b0};
        end
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !done_q)
    else $error("divider done while busy");
`endif

endmodule

### design/simc_back.sv
module simc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  simc_pkg::cfg_t   cfg_i,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  simc_pkg::job_t   job_i,
  output logic             empty,
  input  logic             pop,
  output simc_pkg::out_t   out_data_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_APPLY, S_MUL, S_UNIT, S_DECIDE, S_DMAX, S_MAXD, S_DREM, S_DPPF, S_DONE
  } state_e;

  state_e                  state_q;
  simc_pkg::job_t          job_q;
  logic [15:0]             w_q [simc_pkg::NUM_MODES];
  logic [15:0]             h_q [simc_pkg::NUM_MODES];
  logic [15:0]             ox_q [simc_pkg::NUM_MODES];
  logic [15:0]             oy_q [simc_pkg::NUM_MODES];
  logic [7:0]              cid_q [simc_pkg::NUM_MODES];
  logic [18:0]             pkt_q [simc_pkg::NUM_MODES];
  logic [31:0]             wh_q, fr_q, rd_q;
  logic [21:0]             line_q;
  logic [18:0]             u_q, mx_q;
  logic                    rc_q;
  simc_pkg::out_t          out_q;
  logic                    out_vld_q;
  logic                    div_start;
  logic [31:0]             div_dvd;
  logic                    div_done;
  logic [31:0]             div_quot;
  logic [18:0]             div_rem;
  logic [simc_pkg::MIDX_W-1:0] mi;
  logic [5:0]              bits;
  logic [37:0]             fprod;
  logic [34:0]             mprod;
  logic [18:0]             u_new;
  logic [15:0]             b;
  logic                    out_free;

  assign mi          = simc_pkg::midx(job_q.mode);
  assign bits        = simc_pkg::bits_of(cid_q[mi]);
  assign fprod       = 38'(wh_q) * 38'(bits);
  assign mprod       = 35'(div_quot) * 35'(u_q);
  assign u_new       = simc_pkg::unit_from_line(line_q);
  assign b           = job_q.data[31:16];
  assign job_ready_o = (state_q == S_IDLE);
  assign empty       = !out_vld_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_vld_q || pop;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = 32'(cfg_i.bus_max);
    if (state_q == S_DECIDE) begin
      if (job_q.op == simc_pkg::OP_RD_ENV || job_q.op == simc_pkg::OP_WR_PKT) begin
        div_start = 1'b1;
      end else if (job_q.op == simc_pkg::OP_RD_PPF) begin
        div_start = 1'b1;
        div_dvd   = fr_q + 32'(u_q) - 32'd1;
      end
    end else if (state_q == S_MAXD && job_q.op == simc_pkg::OP_WR_PKT) begin
      div_start = 1'b1;
      div_dvd   = 32'(b);
    end
  end

  simc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (u_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      for (int m = 0; m < simc_pkg::NUM_MODES; m++) begin
        w_q[m]   <= simc_pkg::def_w(m);
        h_q[m]   <= simc_pkg::def_h(m);
        ox_q[m]  <= 16'd0;
        oy_q[m]  <= 16'd0;
        cid_q[m] <= 8'd0;
        pkt_q[m] <= simc_pkg::unit_from_line({3'd0, simc_pkg::def_w(m), 3'd0});
      end
    end else begin
      // the done state reloads the output register itself
      if (pop && out_vld_q && state_q != S_DONE) out_vld_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            job_q   <= job_i;
            rd_q    <= 32'd0;
            rc_q    <= 1'b0;
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          case (job_q.op)
            simc_pkg::OP_WR_POS: begin
              ox_q[mi] <= job_q.data[31:16];
              oy_q[mi] <= job_q.data[15:0];
            end
            simc_pkg::OP_WR_SIZE: begin
              w_q[mi] <= job_q.data[31:16];
              h_q[mi] <= job_q.data[15:0];
            end
            simc_pkg::OP_WR_CODING: cid_q[mi] <= job_q.data[31:24];
            default: ;
          endcase
          state_q <= job_q.mode_ok ? S_MUL : S_DONE;
        end
        S_MUL: begin
          wh_q    <= 32'(w_q[mi]) * 32'(h_q[mi]);
          line_q  <= 22'(w_q[mi]) * 22'(bits);
          state_q <= S_UNIT;
        end
        S_UNIT: begin
          fr_q    <= fprod[34:3];
          u_q     <= u_new;
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          state_q <= S_DONE;
          case (job_q.op)
            simc_pkg::OP_RD_MAXSZ:  rd_q <= simc_pkg::max_word(job_q.mode);
            simc_pkg::OP_RD_UNITSZ: rd_q <= simc_pkg::unit_word(job_q.mode);
            simc_pkg::OP_RD_POS:    rd_q <= {ox_q[mi], oy_q[mi]};
            simc_pkg::OP_RD_SIZE:   rd_q <= {w_q[mi], h_q[mi]};
            simc_pkg::OP_RD_CODING: rd_q <= {cid_q[mi], 24'd0};
            simc_pkg::OP_RD_INQ:    rd_q <= cfg_i.mask[job_q.mode];
            simc_pkg::OP_RD_PIX:    rd_q <= wh_q;
            simc_pkg::OP_RD_FRAME:  rd_q <= fr_q;
            simc_pkg::OP_RD_PKT:    rd_q <= {u_q[15:0], 16'd0};
            simc_pkg::OP_RD_ENV, simc_pkg::OP_WR_PKT: state_q <= S_DMAX;
            simc_pkg::OP_RD_PPF:    state_q <= S_DPPF;
            simc_pkg::OP_WR_SIZE, simc_pkg::OP_WR_CODING: pkt_q[mi] <= u_q;
            default: ;
          endcase
        end
        S_DMAX: begin
          if (div_done) begin
            // quotient times unit never exceeds the bus limit
            mx_q    <= (mprod[18:0] < u_q) ? u_q : mprod[18:0];
            state_q <= S_MAXD;
          end
        end
        S_MAXD: begin
          if (job_q.op == simc_pkg::OP_WR_PKT) begin
            state_q <= S_DREM;
          end else begin
            rd_q    <= {u_q[15:0], 16'd0} | {13'd0, mx_q};
            state_q <= S_DONE;
          end
        end
        S_DREM: begin
          if (div_done) begin
            if ((19'(b) >= u_q) && (19'(b) <= mx_q) && (div_rem == 19'd0))
              pkt_q[mi] <= 19'(b);
            else
              rc_q <= 1'b1;
            state_q <= S_DONE;
          end
        end
        S_DPPF: begin
          if (div_done) begin
            rd_q    <= div_quot;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_q.read_data        <= rd_q;
            out_q.response_code    <= rc_q;
            out_q.packet_bytes_now <= job_q.mode_ok ? pkt_q[mi] : 19'd0;
            out_vld_q              <= 1'b1;
            state_q                <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == S_DONE)
    else $error("result loaded outside done state");
  a_rc_only_pkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && rc_q) |-> job_q.op == simc_pkg::OP_WR_PKT)
    else $error("data error on non packet-size access");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_ready_o |-> !div_done)
    else $error("divider result while idle");
`endif

endmodule

### design/scalable_image_mode_csr_top.sv
// Channel   Handshake            Payload
// input     push / full          in_data_i  (cmd, mode_index, reg_offset, write_data)
// result    empty / pop          out_data_o (read_data, response_code, packet_bytes_now)
// config    cfg_valid_i / ready  cfg_index_i, cfg_data_i
// An access passes the back sequencer's states, plus each division on the shared
// bit-serial divider and the envelope step: envelope read one division and the envelope step,
// packets-per-frame read one division, packet-size write two (bus limit over unit, then size over unit).
// A two-entry queue decouples acceptance from execution; a one-entry output
// register holds the result until popped, stalling only the back sequencer.
// Reset is asynchronous, active low; modes return to table geometry at once.
module scalable_image_mode_csr_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  simc_pkg::in_t                   in_data_i,
  output logic                            empty,
  input  logic                            pop,
  output simc_pkg::out_t                  out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [simc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);

  simc_pkg::cfg_t cfg_q;
  simc_pkg::job_t job;
  logic           job_valid, job_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bus_max <= 16'd4096;
      cfg_q.mask    <= '0;
    end else if (cfg_valid_i) begin
      case (simc_pkg::cfg_idx_e'(cfg_index_i))
        simc_pkg::CFG_BUS_MAX: cfg_q.bus_max <= cfg_data_i[15:0];
        simc_pkg::CFG_MASK0:   cfg_q.mask[0] <= cfg_data_i;
        simc_pkg::CFG_MASK1:   cfg_q.mask[1] <= cfg_data_i;
        simc_pkg::CFG_MASK2:   cfg_q.mask[2] <= cfg_data_i;
        simc_pkg::CFG_MASK3:   cfg_q.mask[3] <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  simc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  simc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule
